// ===== hw/rtl/sktu_pkg.sv =====
// sktu_pkg: shared constants and types for the sorted key table unit
// depends on nothing; used by sorted_key_table_unit and its testbench
`timescale 1ns / 1ps
`default_nettype none

package sktu_pkg;

  localparam int CAPACITY = 64;
  localparam int KEY_BITS = 32;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int MODE_W   = 3;
  localparam int STAT_W   = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_INSERT = 3'd0,
    MODE_DELETE = 3'd1,
    MODE_LOOKUP = 3'd2,
    MODE_CLEAR  = 3'd3,
    MODE_REWIND = 3'd4,
    MODE_NEXT   = 3'd5
  } mode_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_EMPTY     = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_INS_HEAD,
    S_SCAN,
    S_DEL_SHIFT,
    S_NEXT
  } state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/sorted_key_table_unit.sv =====
// sorted_key_table_unit: sorted key table with insert, delete, lookup, clear and iterator
// depends on sktu_pkg and sktu_ram
`timescale 1ns / 1ps
`default_nettype none

// Keeps up to 64 keys in ascending order in one ram with a single read port.
// A command is taken when start is high and busy is low; its result comes as
// a one-cycle done pulse with status, found, key_out and count, and must be
// captured in that cycle since the receiver cannot hold it off. Clear, rewind,
// unused modes, an insert into an empty table and commands that fail at once
// (full table, empty table) give done in the next cycle. Any other insert
// walks down from the last entry, moving each key not below the new one up a
// slot, then writes it; a delete or lookup scans up from the first entry; a
// read next fetches the entry at the iterator. The ram read port walks one
// entry per cycle while the write port shifts the entry read the cycle before.
module sorted_key_table_unit (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic [sktu_pkg::MODE_W-1:0]         mode,
  input  wire logic [sktu_pkg::KEY_BITS-1:0]       key,
  output logic                                     done,
  output logic      [sktu_pkg::STAT_W-1:0]         status,
  output logic                                     found,
  output logic      [sktu_pkg::KEY_BITS-1:0]       key_out,
  output logic      [sktu_pkg::CNT_W-1:0]          count
);

  localparam int ADDR_W = sktu_pkg::ADDR_W;
  localparam int CNT_W  = sktu_pkg::CNT_W;
  localparam int KB     = sktu_pkg::KEY_BITS;

  sktu_pkg::state_t state, state_next;
  sktu_pkg::mode_t  op_mode;
  logic [KB-1:0]    op_key;
  logic [ADDR_W-1:0] ptr, ptr_next;
  logic [CNT_W-1:0]  entry_count, entry_count_next;
  logic [ADDR_W-1:0] iter_pos, iter_pos_next;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [KB-1:0]     ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [KB-1:0]     ram_rdata;

  logic              res_load;
  sktu_pkg::status_t res_status;
  logic              res_found;
  logic [KB-1:0]     res_key;

  logic              accept;
  sktu_pkg::mode_t   in_mode;
  logic [CNT_W-1:0]  ptr_inc;
  logic              last;
  logic [ADDR_W-1:0] next_pos;

  assign busy    = (state != sktu_pkg::S_IDLE);
  assign accept  = start && !busy;
  assign in_mode = sktu_pkg::mode_t'(mode);
  assign ptr_inc = CNT_W'(ptr) + CNT_W'(1);
  assign last    = (ptr_inc == entry_count);
  assign next_pos = (CNT_W'(iter_pos) >= entry_count) ? '0 : iter_pos;

  sktu_ram #(
    .DEPTH(sktu_pkg::CAPACITY),
    .WIDTH(KB)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      sktu_pkg::S_IDLE: begin
        if (accept) begin
          case (in_mode)
            sktu_pkg::MODE_INSERT: begin
              if (entry_count < CNT_W'(sktu_pkg::CAPACITY) && entry_count != '0) begin
                state_next = sktu_pkg::S_INS;
              end
            end
            sktu_pkg::MODE_DELETE, sktu_pkg::MODE_LOOKUP: begin
              if (entry_count != '0) begin
                state_next = sktu_pkg::S_SCAN;
              end
            end
            sktu_pkg::MODE_NEXT: begin
              if (entry_count != '0) begin
                state_next = sktu_pkg::S_NEXT;
              end
            end
            default: state_next = sktu_pkg::S_IDLE;
          endcase
        end
      end
      sktu_pkg::S_INS: begin
        if (ram_rdata >= op_key) begin
          if (ptr == '0) begin
            state_next = sktu_pkg::S_INS_HEAD;
          end
        end else begin
          state_next = sktu_pkg::S_IDLE;
        end
      end
      sktu_pkg::S_INS_HEAD: state_next = sktu_pkg::S_IDLE;
      sktu_pkg::S_SCAN: begin
        if (ram_rdata < op_key) begin
          if (last) begin
            state_next = sktu_pkg::S_IDLE;
          end
        end else if (ram_rdata == op_key && op_mode == sktu_pkg::MODE_DELETE && !last) begin
          state_next = sktu_pkg::S_DEL_SHIFT;
        end else begin
          state_next = sktu_pkg::S_IDLE;
        end
      end
      sktu_pkg::S_DEL_SHIFT: begin
        if (last) begin
          state_next = sktu_pkg::S_IDLE;
        end
      end
      sktu_pkg::S_NEXT: state_next = sktu_pkg::S_IDLE;
      default: state_next = sktu_pkg::S_IDLE;
    endcase
  end

  // datapath and ram control
  always_comb begin
    ram_we           = 1'b0;
    ram_waddr        = '0;
    ram_wdata        = op_key;
    ram_raddr        = ptr;
    ptr_next         = ptr;
    entry_count_next = entry_count;
    iter_pos_next    = iter_pos;
    res_load         = 1'b0;
    res_status       = sktu_pkg::ST_OK;
    res_found        = 1'b0;
    res_key          = '0;
    case (state)
      sktu_pkg::S_IDLE: begin
        if (accept) begin
          case (in_mode)
            sktu_pkg::MODE_INSERT: begin
              iter_pos_next = '0;
              if (entry_count >= CNT_W'(sktu_pkg::CAPACITY)) begin
                res_load   = 1'b1;
                res_status = sktu_pkg::ST_FULL;
              end else if (entry_count == '0) begin
                ram_we           = 1'b1;
                ram_waddr        = '0;
                ram_wdata        = key;
                entry_count_next = CNT_W'(1);
                res_load         = 1'b1;
              end else begin
                ram_raddr = ADDR_W'(entry_count - CNT_W'(1));
                ptr_next  = ADDR_W'(entry_count - CNT_W'(1));
              end
            end
            sktu_pkg::MODE_DELETE, sktu_pkg::MODE_LOOKUP: begin
              if (in_mode == sktu_pkg::MODE_DELETE) begin
                iter_pos_next = '0;
              end
              if (entry_count == '0) begin
                res_load   = 1'b1;
                res_status = sktu_pkg::ST_NOT_FOUND;
              end else begin
                ram_raddr = '0;
                ptr_next  = '0;
              end
            end
            sktu_pkg::MODE_CLEAR: begin
              entry_count_next = '0;
              iter_pos_next    = '0;
              res_load         = 1'b1;
            end
            sktu_pkg::MODE_REWIND: begin
              iter_pos_next = '0;
              res_load      = 1'b1;
            end
            sktu_pkg::MODE_NEXT: begin
              if (entry_count == '0) begin
                iter_pos_next = '0;
                res_load      = 1'b1;
                res_status    = sktu_pkg::ST_EMPTY;
              end else begin
                ram_raddr = next_pos;
                ptr_next  = next_pos;
              end
            end
            default: res_load = 1'b1;
          endcase
        end
      end
      sktu_pkg::S_INS: begin
        ram_we    = 1'b1;
        ram_waddr = ptr + ADDR_W'(1);
        if (ram_rdata >= op_key) begin
          ram_wdata = ram_rdata;
          if (ptr != '0) begin
            ram_raddr = ptr - ADDR_W'(1);
            ptr_next  = ptr - ADDR_W'(1);
          end
        end else begin
          ram_wdata        = op_key;
          entry_count_next = entry_count + CNT_W'(1);
          res_load         = 1'b1;
        end
      end
      sktu_pkg::S_INS_HEAD: begin
        ram_we           = 1'b1;
        ram_waddr        = '0;
        ram_wdata        = op_key;
        entry_count_next = entry_count + CNT_W'(1);
        res_load         = 1'b1;
      end
      sktu_pkg::S_SCAN: begin
        if (ram_rdata < op_key) begin
          if (last) begin
            res_load   = 1'b1;
            res_status = sktu_pkg::ST_NOT_FOUND;
          end else begin
            ram_raddr = ptr + ADDR_W'(1);
            ptr_next  = ptr + ADDR_W'(1);
          end
        end else if (ram_rdata != op_key) begin
          res_load   = 1'b1;
          res_status = sktu_pkg::ST_NOT_FOUND;
        end else if (op_mode == sktu_pkg::MODE_DELETE) begin
          if (last) begin
            entry_count_next = entry_count - CNT_W'(1);
            res_load         = 1'b1;
            res_found        = 1'b1;
          end else begin
            ram_raddr = ptr + ADDR_W'(1);
            ptr_next  = ptr + ADDR_W'(1);
          end
        end else begin
          res_load  = 1'b1;
          res_found = 1'b1;
          res_key   = ram_rdata;
        end
      end
      sktu_pkg::S_DEL_SHIFT: begin
        ram_we    = 1'b1;
        ram_waddr = ptr - ADDR_W'(1);
        ram_wdata = ram_rdata;
        if (last) begin
          entry_count_next = entry_count - CNT_W'(1);
          res_load         = 1'b1;
          res_found        = 1'b1;
        end else begin
          ram_raddr = ptr + ADDR_W'(1);
          ptr_next  = ptr + ADDR_W'(1);
        end
      end
      sktu_pkg::S_NEXT: begin
        res_load      = 1'b1;
        res_key       = ram_rdata;
        iter_pos_next = last ? '0 : ptr + ADDR_W'(1);
      end
      default: res_load = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= sktu_pkg::S_IDLE;
      entry_count <= '0;
      iter_pos    <= '0;
      done        <= 1'b0;
    end else begin
      state       <= state_next;
      entry_count <= entry_count_next;
      iter_pos    <= iter_pos_next;
      done        <= res_load;
    end
  end

  always_ff @(posedge clk) begin
    ptr <= ptr_next;
    if (accept) begin
      op_mode <= in_mode;
      op_key  <= key;
    end
    if (res_load) begin
      status  <= res_status;
      found   <= res_found;
      key_out <= res_key;
      count   <= entry_count_next;
    end
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while a command is in flight");

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CNT_W'(sktu_pkg::CAPACITY))
    else $error("entry count above capacity");

  a_iter_range: assert property (@(posedge clk) disable iff (rst)
    (CNT_W'(iter_pos) < entry_count) || (iter_pos == '0))
    else $error("iterator beyond stored entries");

  a_clear_word: assert property (@(posedge clk) disable iff (rst)
    accept && (mode == sktu_pkg::MODE_CLEAR) |=> done && (count == '0))
    else $error("clear did not report an empty table");

endmodule

`default_nettype wire

// ===== hw/rtl/sktu_ram.sv =====
// sktu_ram: simple dual-port synchronous ram, one write and one read port
// read data registered; no package dependency
`timescale 1ns / 1ps
`default_nettype none

module sktu_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire
